// ----- rtl/sequenced_ring_log_store_core_macros.svh -----
// ----------------------------------------------------------------------------
// Sequenced ring log store: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_RING_LOG_STORE_CORE_MACROS_SVH
`define SEQUENCED_RING_LOG_STORE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRLS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srls port check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srls port check failed");

`endif

// ----- rtl/srls_pkg.sv -----
// ----------------------------------------------------------------------------
// Sequenced ring log store package
// Operation and status codes, item types and fixed widths.
// ----------------------------------------------------------------------------
package srls_pkg;

  localparam int CAP_W = 11;
  // Search positions span up to twice the capacity.
  localparam int SRCH_W = 13;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_READ    = 3'd1,
    OP_REWRITE = 3'd2,
    OP_FIND    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NONE  = 2'd1,
    ST_LATER = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] seq;
    logic [63:0] stamp;
    logic [63:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] entry_seq;
    logic [63:0] entry_stamp;
    logic [63:0] entry_payload;
    logic [63:0] oldest_seq;
    logic [63:0] newest_seq;
    logic [63:0] oldest_stamp;
    logic [63:0] newest_stamp;
  } out_item_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_INSL = 11'b00000000010,
    S_CHK  = 11'b00000000100,
    S_LOOK = 11'b00000001000,
    S_RD   = 11'b00000010000,
    S_RDW  = 11'b00000100000,
    S_FCHK = 11'b00001000000,
    S_PRB  = 11'b00010000000,
    S_PCMP = 11'b00100000000,
    S_DUP  = 11'b01000000000,
    S_DCMP = 11'b10000000000
  } state_t;

endpackage

// ----- rtl/sequenced_ring_log_store_core.sv -----
// ----------------------------------------------------------------------------
// Sequenced ring log store core
// Ring of log entries with sequence numbering, lookup and stamp search.
// ----------------------------------------------------------------------------
// One item is taken while busy is low; its single result appears on out_item
// for exactly one cycle with out_strobe high, and the receiver cannot stall
// it. All entry accesses go through one entry memory with a write port and a
// registered read port. Clear and an unknown operation finish in idle; an
// insert passes S_INSL only when the ring is full; rewrite passes S_CHK and
// S_LOOK, a read also S_RD and S_RDW; find by stamp passes S_FCHK, S_PRB and
// S_PCMP per probe, with at most floor(log2(entries held)) + 1 probes, S_DUP
// and S_DCMP per earlier entry with the same stamp, then S_RD and S_RDW.
// Writing the capacity register empties the store at once; it is taken only
// while busy is low, and an item offered in that same cycle waits.
module sequenced_ring_log_store_core #(
  parameter int DEPTH        = 1024,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  srls_pkg::in_item_t in_item,
  output logic               out_strobe,
  output srls_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata
);
  import srls_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = 128 + PAYLOAD_BITS;
  localparam logic [CAP_W-1:0] CAP_MAX = (DEPTH > 2047) ? 11'd2047 : CAP_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RST = (DEPTH < 1024) ? CAP_W'(DEPTH) : 11'd1024;

  state_t                  state_r;
  logic [2:0]              op_r;
  logic [63:0]             seq_in_r, stamp_in_r;
  logic [PAYLOAD_BITS-1:0] pay_in_r;
  logic [CAP_W-1:0]        cap_r, held_r;
  logic [AW-1:0]           head_r, tail_r, pos_r;
  logic [63:0]             low_seq_r, high_seq_r, low_stamp_r, high_stamp_r;
  logic [63:0]             delta_r;
  logic [SRCH_W-1:0]       lo_r, hi_r, mid_r, later_r;
  logic                    seen_r;
  logic [1:0]              stat_r;
  logic                    strobe_r;
  logic [1:0]              ostat_r;
  logic [63:0]             eseq_r, estamp_r, epay_r;

  logic [EW-1:0]           mem_r [DEPTH];
  logic [EW-1:0]           rdata_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [EW-1:0]           mem_wdata;

  logic [63:0]             rd_seq, rd_stamp, rd_pay;
  logic [63:0]             high_seq_inc;
  logic [SRCH_W-1:0]       mid_c;
  logic [CAP_W-1:0]        cap_c;

  function automatic logic [AW-1:0] wrap_f(input logic [SRCH_W-1:0] u);
    logic [SRCH_W-1:0] p;
    p = (u >= SRCH_W'(cap_r)) ? u - SRCH_W'(cap_r) : u;
    return AW'(p);
  endfunction

  assign rd_seq       = rdata_r[EW-1 -: 64];
  assign rd_stamp     = rdata_r[PAYLOAD_BITS +: 64];
  assign rd_pay       = 64'(rdata_r[PAYLOAD_BITS-1:0]);
  assign high_seq_inc = (&high_seq_r) ? 64'd1 : high_seq_r + 64'd1;
  assign mid_c        = SRCH_W'((SRCH_W+1)'(lo_r) + (SRCH_W+1)'(hi_r) >> 1);

  always_comb begin
    cap_c = cfg_wdata;
    if (cap_c > CAP_MAX) cap_c = CAP_MAX;
    if (cap_c < 11'd2) cap_c = 11'd2;
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tail_r;
    mem_wdata = {high_seq_inc, in_item.stamp, in_item.payload[PAYLOAD_BITS-1:0]};
    mem_raddr = pos_r;
    case (state_r)
      S_IDLE: begin
        if (start && !cfg_we && in_item.op == OP_INSERT) begin
          mem_we    = 1'b1;
          mem_waddr = (held_r == '0) ? tail_r : wrap_f(SRCH_W'(tail_r) + 1'b1);
          mem_raddr = wrap_f(SRCH_W'(head_r) + 1'b1);
        end
      end
      S_LOOK: begin
        if (op_r == OP_REWRITE) begin
          mem_we    = (delta_r < 64'(held_r));
          mem_waddr = wrap_f(SRCH_W'(head_r) + SRCH_W'(delta_r[CAP_W-1:0]));
          mem_wdata = {seq_in_r, stamp_in_r, pay_in_r};
        end
      end
      S_PRB:   mem_raddr = wrap_f(mid_c);
      S_DUP:   mem_raddr = wrap_f(mid_r - 1'b1);
      default: mem_raddr = pos_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_waddr] <= mem_wdata;
    rdata_r <= mem_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= CAP_RST;
      held_r       <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      low_seq_r    <= '0;
      high_seq_r   <= '0;
      low_stamp_r  <= '0;
      high_stamp_r <= '0;
      strobe_r     <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            cap_r        <= cap_c;
            held_r       <= '0;
            head_r       <= '0;
            tail_r       <= '0;
            low_seq_r    <= '0;
            high_seq_r   <= '0;
            low_stamp_r  <= '0;
            high_stamp_r <= '0;
          end else if (start) begin
            op_r       <= in_item.op;
            seq_in_r   <= in_item.seq;
            stamp_in_r <= in_item.stamp;
            pay_in_r   <= in_item.payload[PAYLOAD_BITS-1:0];
            eseq_r     <= '0;
            estamp_r   <= '0;
            epay_r     <= '0;
            ostat_r    <= ST_NONE;
            case (in_item.op)
              OP_INSERT: begin
                high_seq_r <= high_seq_inc;
                eseq_r     <= high_seq_inc;
                estamp_r   <= in_item.stamp;
                epay_r     <= 64'(in_item.payload[PAYLOAD_BITS-1:0]);
                ostat_r    <= ST_DONE;
                high_stamp_r <= in_item.stamp;
                if (held_r == '0) begin
                  held_r      <= 11'd1;
                  low_seq_r   <= high_seq_inc;
                  low_stamp_r <= in_item.stamp;
                  strobe_r    <= 1'b1;
                end else if (held_r >= cap_r) begin
                  head_r  <= wrap_f(SRCH_W'(head_r) + 1'b1);
                  tail_r  <= wrap_f(SRCH_W'(tail_r) + 1'b1);
                  state_r <= S_INSL;
                end else begin
                  held_r   <= held_r + 1'b1;
                  tail_r   <= wrap_f(SRCH_W'(tail_r) + 1'b1);
                  strobe_r <= 1'b1;
                end
              end
              OP_READ, OP_REWRITE: state_r <= S_CHK;
              OP_FIND:             state_r <= S_FCHK;
              OP_CLEAR: begin
                held_r       <= '0;
                head_r       <= '0;
                tail_r       <= '0;
                low_seq_r    <= '0;
                high_seq_r   <= '0;
                low_stamp_r  <= '0;
                high_stamp_r <= '0;
                ostat_r      <= ST_DONE;
                strobe_r     <= 1'b1;
              end
              default: strobe_r <= 1'b1;
            endcase
          end
        end
        S_INSL: begin
          // The entry after the dropped one becomes the oldest.
          low_seq_r   <= rd_seq;
          low_stamp_r <= rd_stamp;
          strobe_r    <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_CHK: begin
          delta_r <= seq_in_r - low_seq_r;
          if (held_r == '0 || seq_in_r < low_seq_r || seq_in_r > high_seq_r) begin
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          pos_r  <= wrap_f(SRCH_W'(head_r) + SRCH_W'(delta_r[CAP_W-1:0]));
          stat_r <= ST_DONE;
          if (delta_r >= 64'(held_r)) begin
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end else if (op_r == OP_REWRITE) begin
            eseq_r   <= seq_in_r;
            estamp_r <= stamp_in_r;
            epay_r   <= 64'(pay_in_r);
            ostat_r  <= ST_DONE;
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          eseq_r   <= rd_seq;
          estamp_r <= rd_stamp;
          epay_r   <= rd_pay;
          ostat_r  <= stat_r;
          strobe_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        S_FCHK: begin
          lo_r   <= SRCH_W'(head_r);
          hi_r   <= (tail_r < head_r) ? SRCH_W'(tail_r) + SRCH_W'(cap_r) : SRCH_W'(tail_r);
          seen_r <= 1'b0;
          if (held_r == '0 || stamp_in_r < low_stamp_r || stamp_in_r > high_stamp_r) begin
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            state_r <= S_PRB;
          end
        end
        S_PRB: begin
          if (hi_r >= lo_r) begin
            mid_r   <= mid_c;
            state_r <= S_PCMP;
          end else begin
            pos_r   <= seen_r ? wrap_f(later_r) : tail_r;
            stat_r  <= ST_LATER;
            state_r <= S_RD;
          end
        end
        S_PCMP: begin
          if (rd_stamp == stamp_in_r) begin
            state_r <= S_DUP;
          end else if (rd_stamp < stamp_in_r) begin
            lo_r    <= mid_r + 1'b1;
            state_r <= S_PRB;
          end else begin
            later_r <= mid_r;
            seen_r  <= 1'b1;
            if (mid_r == '0) begin
              pos_r   <= wrap_f(mid_r);
              stat_r  <= ST_LATER;
              state_r <= S_RD;
            end else begin
              hi_r    <= mid_r - 1'b1;
              state_r <= S_PRB;
            end
          end
        end
        S_DUP: begin
          if (mid_r > lo_r) begin
            state_r <= S_DCMP;
          end else begin
            pos_r   <= wrap_f(mid_r);
            stat_r  <= ST_DONE;
            state_r <= S_RD;
          end
        end
        S_DCMP: begin
          // Walk back while the previous entry carries the same stamp.
          if (rd_stamp == stamp_in_r) begin
            mid_r   <= mid_r - 1'b1;
            state_r <= S_DUP;
          end else begin
            pos_r   <= wrap_f(mid_r);
            stat_r  <= ST_DONE;
            state_r <= S_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

  always_comb begin
    out_item.status        = ostat_r;
    out_item.entry_seq     = eseq_r;
    out_item.entry_stamp   = estamp_r;
    out_item.entry_payload = epay_r;
    out_item.oldest_seq    = low_seq_r;
    out_item.newest_seq    = high_seq_r;
    out_item.oldest_stamp  = low_stamp_r;
    out_item.newest_stamp  = high_stamp_r;
  end

endmodule

// ----- rtl/srls_checker.sv -----
// ----------------------------------------------------------------------------
// Sequenced ring log store port checker
// Watches the top-level ports for sequencing and result-format slips.
// ----------------------------------------------------------------------------
`include "sequenced_ring_log_store_core_macros.svh"

module srls_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input srls_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input srls_pkg::out_item_t out_item,
  input logic                cfg_we
);
  import srls_pkg::*;

  logic accept;
  assign accept = start && !busy && !cfg_we;

  `SRLS_ASSERT_NEXT(a_accept_busy, accept && in_item.op == OP_FIND, busy)
  // A result is only ever presented once the block is back to idle.
  `SRLS_ASSERT_SAME(a_strobe_idle, out_strobe, !busy)
  `SRLS_ASSERT_SAME(a_status_code, out_strobe, out_item.status != 2'd3)
  `SRLS_ASSERT_SAME(a_none_zero, out_strobe && out_item.status == ST_NONE,
    out_item.entry_seq == 64'd0 && out_item.entry_stamp == 64'd0)

endmodule

bind sequenced_ring_log_store_core srls_checker u_srls_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
  .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sequenced ring log store testbench
// Drives directed and random commands through the start/busy port, predicts
// results with an in-bench ring model or the directed rows, checks each strobe.
// ----------------------------------------------------------------------------
module tb_top;
  import srls_pkg::*;

  localparam int          RING_DEPTH = 1024;
  localparam int          STALL_LIMIT = 20000;
  localparam logic [2:0]  OP_RSVD_A = 3'd5;
  localparam logic [2:0]  OP_RSVD_B = 3'd6;
  localparam logic [2:0]  OP_RSVD_C = 3'd7;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;

  sequenced_ring_log_store_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the ring.
  logic [63:0] seq_mem [RING_DEPTH];
  logic [63:0] stamp_mem [RING_DEPTH];
  logic [63:0] pay_mem [RING_DEPTH];
  int          head_pos, tail_pos, held, ring_cap;
  logic [63:0] low_seq_q, high_seq_q, low_stamp_q, high_stamp_q;

  out_item_t   pending_results[$];
  int          error_count = 0;
  int          idle_pct = 0;
  int          quiet_cycles = 0;
  logic [63:0] stamp_run;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t want;
  } row_t;
  row_t        directed[$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int ring_wrap(input int u);
    int p;
    p = (u >= ring_cap) ? u - ring_cap : u;
    return (p < RING_DEPTH) ? p : 0;
  endfunction

  function automatic void empty_ring();
    head_pos = 0;
    tail_pos = 0;
    held = 0;
    low_seq_q = '0;
    high_seq_q = '0;
    low_stamp_q = '0;
    high_stamp_q = '0;
  endfunction

  // Position of a held sequence number, or -1 when it is out of range.
  function automatic int seq_position(input logic [63:0] s);
    logic [63:0] delta;
    if (held == 0 || s < low_seq_q || s > high_seq_q) return -1;
    delta = s - low_seq_q;
    if (delta >= held) return -1;
    return ring_wrap(head_pos + int'(delta));
  endfunction

  function automatic out_item_t ring_step(input in_item_t c);
    out_item_t   r;
    int          pos, lo, hi, mid, later;
    bit          seen_later, hit;
    logic [63:0] v;
    r = '0;
    r.status = ST_NONE;
    case (c.op)
      OP_INSERT: begin
        high_seq_q = (high_seq_q == ALL_ONES) ? 64'd1 : high_seq_q + 64'd1;
        if (held == 0) begin
          held = 1;
          low_seq_q = high_seq_q;
          low_stamp_q = c.stamp;
          high_stamp_q = c.stamp;
        end else if (held >= ring_cap) begin
          head_pos = ring_wrap(head_pos + 1);
          low_seq_q = seq_mem[head_pos];
          low_stamp_q = stamp_mem[head_pos];
          tail_pos = ring_wrap(tail_pos + 1);
          high_stamp_q = c.stamp;
        end else begin
          high_stamp_q = c.stamp;
          held++;
          tail_pos = ring_wrap(tail_pos + 1);
        end
        seq_mem[tail_pos] = high_seq_q;
        stamp_mem[tail_pos] = c.stamp;
        pay_mem[tail_pos] = c.payload;
        pos = tail_pos;
        r.status = ST_DONE;
      end
      OP_READ, OP_REWRITE: begin
        pos = seq_position(c.seq);
        if (pos >= 0) begin
          if (c.op == OP_REWRITE) begin
            seq_mem[pos] = c.seq;
            stamp_mem[pos] = c.stamp;
            pay_mem[pos] = c.payload;
          end
          r.status = ST_DONE;
        end
      end
      OP_FIND: begin
        if (held != 0 && c.stamp >= low_stamp_q && c.stamp <= high_stamp_q) begin
          lo = head_pos;
          hi = tail_pos;
          mid = lo;
          later = 0;
          seen_later = 1'b0;
          hit = 1'b0;
          if (hi < lo) hi += ring_cap;
          while (hi >= lo) begin
            mid = (lo + hi) >> 1;
            v = stamp_mem[ring_wrap(mid)];
            if (v == c.stamp) begin
              hit = 1'b1;
              break;
            end else if (v < c.stamp) begin
              lo = mid + 1;
            end else begin
              later = mid;
              seen_later = 1'b1;
              if (mid == 0) break;
              hi = mid - 1;
            end
          end
          if (hit) begin
            // Walk back to the earliest duplicate above the lower bound.
            while (mid > lo && stamp_mem[ring_wrap(mid - 1)] == c.stamp) mid--;
            pos = ring_wrap(mid);
            r.status = ST_DONE;
          end else begin
            pos = seen_later ? ring_wrap(later) : tail_pos;
            r.status = ST_LATER;
          end
        end
      end
      OP_CLEAR: begin
        empty_ring();
        r.status = ST_DONE;
      end
      default: ;
    endcase
    if (r.status != ST_NONE && c.op != OP_CLEAR) begin
      r.entry_seq = seq_mem[pos];
      r.entry_stamp = stamp_mem[pos];
      r.entry_payload = pay_mem[pos];
    end
    r.oldest_seq = low_seq_q;
    r.newest_seq = high_seq_q;
    r.oldest_stamp = low_stamp_q;
    r.newest_stamp = high_stamp_q;
    return r;
  endfunction

  // Offers one item, honoring the sender idle rate, and records its result.
  task automatic issue(input in_item_t c, input bit typed, input out_item_t want);
    out_item_t p;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy);
    p = ring_step(c);
    pending_results.push_back(typed ? want : p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [10:0] value);
    int c;
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    c = (value > RING_DEPTH) ? RING_DEPTH : int'(value);
    ring_cap = (c < 2) ? 2 : c;
    empty_ring();
    stamp_run = {$urandom, $urandom} >> $urandom_range(1, 40);
  endtask

  function automatic void add_row(input logic [2:0] op, input logic [63:0] s,
                                  input logic [63:0] st, input logic [63:0] pl,
                                  input bit typed, input out_item_t want);
    row_t r;
    r.cmd = '{op: op, seq: s, stamp: st, payload: pl};
    r.typed = typed;
    r.want = want;
    directed.push_back(r);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t random_command();
    in_item_t    c;
    int          pick, pos;
    logic [63:0] s;
    c.seq = rand64();
    c.stamp = rand64();
    c.payload = rand64();
    pick = $urandom_range(0, 99);
    s = low_seq_q + 64'($urandom_range(0, held + 1));
    if (pick < 40) begin
      c.op = OP_INSERT;
      if ($urandom_range(0, 9) != 0) begin
        stamp_run += 64'($urandom_range(0, 3));
        c.stamp = stamp_run;
      end
    end else if (pick < 67) begin
      c.op = (pick < 55) ? OP_READ : OP_REWRITE;
      case ($urandom_range(0, 9))
        0: c.seq = 64'd0;
        1: c.seq = high_seq_q + 64'd1;
        2: ;
        default: c.seq = s;
      endcase
      pos = seq_position(c.seq);
      if (pos >= 0 && $urandom_range(0, 4) != 0) c.stamp = stamp_mem[pos];
    end else if (pick < 92) begin
      c.op = OP_FIND;
      pos = seq_position(s);
      case ($urandom_range(0, 9))
        0, 1: ;
        2, 3, 4: c.stamp = low_stamp_q + 64'($urandom_range(0, 2 * held));
        default: if (pos >= 0) c.stamp = stamp_mem[pos];
      endcase
    end else if (pick < 95) begin
      c.op = OP_CLEAR;
    end else begin
      case ($urandom_range(0, 2))
        0: c.op = OP_RSVD_A;
        1: c.op = OP_RSVD_B;
        default: c.op = OP_RSVD_C;
      endcase
    end
    return c;
  endfunction

  // Result checker: the receiver cannot stall, so every strobe is taken.
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report("unexpected result item", 64'd1, 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_item.status !== w.status) report("status", 64'(out_item.status), 64'(w.status));
        if (out_item.entry_seq !== w.entry_seq) report("entry_seq", out_item.entry_seq, w.entry_seq);
        if (out_item.entry_stamp !== w.entry_stamp)
          report("entry_stamp", out_item.entry_stamp, w.entry_stamp);
        if (out_item.entry_payload !== w.entry_payload)
          report("entry_payload", out_item.entry_payload, w.entry_payload);
        if (out_item.oldest_seq !== w.oldest_seq)
          report("oldest_seq", out_item.oldest_seq, w.oldest_seq);
        if (out_item.newest_seq !== w.newest_seq)
          report("newest_seq", out_item.newest_seq, w.newest_seq);
        if (out_item.oldest_stamp !== w.oldest_stamp)
          report("oldest_stamp", out_item.oldest_stamp, w.oldest_stamp);
        if (out_item.newest_stamp !== w.newest_stamp)
          report("newest_stamp", out_item.newest_stamp, w.newest_stamp);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_item_t   none, w;
    logic [10:0] caps [9];
    caps = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd7, 11'd2047, 11'd1024, 11'd1500, 11'd40};
    none = '0;
    none.status = ST_NONE;
    ring_cap = RING_DEPTH;
    empty_ring();
    stamp_run = 64'd100;

    add_row(OP_READ, 64'd0, '0, '0, 1'b1, none);
    add_row(OP_FIND, '0, '0, '0, 1'b1, none);
    add_row(OP_RSVD_A, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, none);
    w = '0;
    w.status = ST_DONE;
    add_row(OP_CLEAR, '0, '0, '0, 1'b1, w);
    w = '{status: ST_DONE, entry_seq: 64'd1, entry_stamp: '0, entry_payload: ALL_ONES,
          oldest_seq: 64'd1, newest_seq: 64'd1, oldest_stamp: '0, newest_stamp: '0};
    add_row(OP_INSERT, ALL_ONES, '0, ALL_ONES, 1'b1, w);
    w = '{status: ST_DONE, entry_seq: 64'd2, entry_stamp: ALL_ONES, entry_payload: '0,
          oldest_seq: 64'd1, newest_seq: 64'd2, oldest_stamp: '0, newest_stamp: ALL_ONES};
    add_row(OP_INSERT, '0, ALL_ONES, '0, 1'b1, w);
    add_row(OP_READ, 64'd1, '0, '0, 1'b0, none);
    add_row(OP_READ, 64'd2, '0, '0, 1'b0, none);
    add_row(OP_READ, 64'd3, '0, '0, 1'b0, none);
    add_row(OP_READ, ALL_ONES, '0, '0, 1'b0, none);
    add_row(OP_REWRITE, 64'd2, 64'd7, 64'h5A5A_A5A5_0F0F_F0F0, 1'b0, none);
    add_row(OP_REWRITE, 64'd9, 64'd7, '0, 1'b0, none);
    add_row(OP_INSERT, '0, 64'd7, 64'h1234, 1'b0, none);
    add_row(OP_INSERT, '0, 64'd7, 64'h5678, 1'b0, none);
    add_row(OP_INSERT, '0, 64'd20, 64'h9ABC, 1'b0, none);
    add_row(OP_FIND, '0, 64'd0, '0, 1'b0, none);
    add_row(OP_FIND, '0, 64'd7, '0, 1'b0, none);
    add_row(OP_FIND, '0, 64'd10, '0, 1'b0, none);
    add_row(OP_FIND, '0, 64'd20, '0, 1'b0, none);
    add_row(OP_FIND, '0, 64'd21, '0, 1'b0, none);
    add_row(OP_RSVD_B, '0, '0, '0, 1'b0, none);
    add_row(OP_RSVD_C, '0, '0, '0, 1'b0, none);
    add_row(OP_CLEAR, '0, '0, '0, 1'b0, none);
    add_row(OP_READ, 64'd1, '0, '0, 1'b0, none);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) issue(directed[i].cmd, directed[i].typed, directed[i].want);

    // Each setting of the ring size gets its own burst of random commands,
    // cycling through the sender idle rates. The receiver cannot stall, so
    // its stalling phase runs with the sender never idle.
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 17;
        default: idle_pct = 0;
      endcase
      repeat (135) issue(random_command(), 1'b0, none);
    end

    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/srls_pkg.sv
rtl/sequenced_ring_log_store_core.sv
rtl/srls_checker.sv
dv/tb_top.sv
